/* rtl/fue_pkg.sv */
// Package for the float ULP error block: constants, shared types and
// leading-zero count helpers. No dependencies.
`default_nettype none

package fue_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MANT_W = 23;
    localparam int unsigned EXP_W  = 8;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    // ULP exponents: zero expected uses 2^-23, subnormal expected 2^-149,
    // otherwise 2^(E-150)
    localparam logic signed [9:0] ZERO_ULP_EXP = -10'sd23;
    localparam logic signed [9:0] SUB_ULP_EXP  = -10'sd149;
    localparam logic signed [9:0] ULP_BIAS     = 10'sd150;

    // Difference magnitude handed from the subtractor to the scaler
    typedef struct packed {
        logic              nan;
        logic [30:0]       mag;
        logic signed [9:0] ulp_exp;
    } t_diff;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd24;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 5'(23 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/fue_if.sv */
// Stream interfaces for the float ULP error block: input pair and result.
// Depends on nothing.
`default_nettype none

interface fue_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] computed_bits;
    logic [31:0] expected_bits;

    modport source (output valid, output computed_bits, output expected_bits, input ready);
    modport sink   (input valid, input computed_bits, input expected_bits, output ready);
endinterface

interface fue_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] ulp_error_bits;

    modport source (output valid, output ulp_error_bits, input ready);
    modport sink   (input valid, input ulp_error_bits, output ready);
endinterface

`default_nettype wire

/* rtl/fue_sub.sv */
// Four-stage single-precision subtractor (round to nearest even), returns
// the difference magnitude and the ULP exponent. Depends on fue_pkg.
`default_nettype none

module fue_sub (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire logic [31:0]  i_computed,
    input  wire logic [31:0]  i_expected,
    output logic              o_valid,
    output fue_pkg::t_diff    o_diff
);
    import fue_pkg::*;

    // stage 1: unpack, order by magnitude
    logic [31:0] a, b, big, sml;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [7:0]  e_big, e_sml, e_big_eff, e_sml_eff, e_dif;
    logic [7:0]  e_exp;
    logic signed [9:0] n_k;

    logic              r1_valid, r1_nan, r1_inf, r1_sub;
    logic [7:0]        r1_e;
    logic [4:0]        r1_d;
    logic [23:0]       r1_sig_a, r1_sig_b;
    logic signed [9:0] r1_k;

    always_comb begin
        a     = i_computed;
        b     = {~i_expected[31], i_expected[30:0]};
        a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != '0);
        b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != '0);
        a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == '0);
        b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == '0);
        if (b[30:0] > a[30:0]) begin
            big = b;
            sml = a;
        end else begin
            big = a;
            sml = b;
        end
        e_big     = big[30:23];
        e_sml     = sml[30:23];
        e_big_eff = (e_big == '0) ? 8'd1 : e_big;
        e_sml_eff = (e_sml == '0) ? 8'd1 : e_sml;
        e_dif     = e_big_eff - e_sml_eff;
        e_exp     = i_expected[30:23];
        if (i_expected[30:0] == '0) begin
            n_k = ZERO_ULP_EXP;
        end else if (e_exp == '0) begin
            n_k = SUB_ULP_EXP;
        end else begin
            n_k = $signed({2'b00, e_exp}) - ULP_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_nan   <= a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
            r1_inf   <= a_inf | b_inf;
            r1_sub   <= a[31] ^ b[31];
            r1_e     <= e_big_eff;
            r1_d     <= (e_dif > 8'd27) ? 5'd28 : e_dif[4:0];
            r1_sig_a <= {e_big != '0, big[22:0]};
            r1_sig_b <= {e_sml != '0, sml[22:0]};
            r1_k     <= n_k;
        end
    end

    // stage 2: align the smaller operand with guard, round and sticky, add
    logic [26:0] m_a, m_b, m_sh, m_mask, m_bs;
    logic        sticky;
    logic [27:0] n_sum;

    logic              r2_valid, r2_nan, r2_inf;
    logic [7:0]        r2_e;
    logic [27:0]       r2_sum;
    logic signed [9:0] r2_k;

    always_comb begin
        m_a    = {r1_sig_a, 3'b000};
        m_b    = {r1_sig_b, 3'b000};
        m_sh   = m_b >> r1_d;
        m_mask = ~({27{1'b1}} << r1_d);
        sticky = |(m_b & m_mask);
        m_bs   = m_sh | {26'b0, sticky};
        if (r1_sub) begin
            n_sum = {1'b0, m_a} - {1'b0, m_bs};
        end else begin
            n_sum = {1'b0, m_a} + {1'b0, m_bs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_nan <= r1_nan;
            r2_inf <= r1_inf;
            r2_e   <= r1_e;
            r2_sum <= n_sum;
            r2_k   <= r1_k;
        end
    end

    // stage 3: normalize, left shift limited by the exponent floor
    logic [4:0]  lz, sh;
    logic [7:0]  lim;
    logic [26:0] n_nrm;
    logic [8:0]  n_e9;

    logic              r3_valid, r3_nan, r3_inf;
    logic [26:0]       r3_nrm;
    logic [8:0]        r3_e9;
    logic signed [9:0] r3_k;

    always_comb begin
        lz  = lzc27(r2_sum[26:0]);
        lim = r2_e - 8'd1;
        sh  = ({3'b000, lz} > lim) ? lim[4:0] : lz;
        if (r2_sum[27]) begin
            n_nrm = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
            n_e9  = {1'b0, r2_e} + 9'd1;
        end else if (r2_sum == '0) begin
            // exact cancellation: land on +0
            n_nrm = '0;
            n_e9  = 9'd1;
        end else begin
            n_nrm = r2_sum[26:0] << sh;
            n_e9  = {1'b0, r2_e} - {4'b0, sh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_nan <= r2_nan;
            r3_inf <= r2_inf;
            r3_nrm <= n_nrm;
            r3_e9  <= n_e9;
            r3_k   <= r2_k;
        end
    end

    // stage 4: round to nearest even and pack; a subnormal lands on e9 = 1
    logic [23:0] mant;
    logic        up;
    logic [31:0] packed_bits;
    t_diff       n_diff;
    logic        r4_valid;
    t_diff       r4_diff;

    always_comb begin
        mant        = r3_nrm[26:3];
        up          = r3_nrm[2] & ((|r3_nrm[1:0]) | mant[0]);
        packed_bits = {r3_e9 - 9'd1, 23'b0} + {8'b0, mant} + {31'b0, up};
        n_diff.nan     = r3_nan;
        n_diff.ulp_exp = r3_k;
        if (r3_inf || packed_bits >= INF_BITS) begin
            n_diff.mag = INF_BITS[30:0];
        end else begin
            n_diff.mag = packed_bits[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_diff <= n_diff;
        end
    end

    assign o_valid = r4_valid;
    assign o_diff  = r4_diff;

endmodule

`default_nettype wire

/* rtl/fue_scale.sv */
// Two-stage exact power-of-two scaler: divides the difference magnitude by
// 2^ulp_exp with overflow to inf and RNE underflow. Depends on fue_pkg.
`default_nettype none

module fue_scale (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  fue_pkg::t_diff     i_diff,
    output logic               o_valid,
    output logic [31:0]        o_bits
);
    import fue_pkg::*;

    // stage 1: normalize the significand, form the target exponent
    logic [7:0]  ed, ed_eff;
    logic [23:0] sig;
    logic [4:0]  lz;
    logic signed [9:0] n_te;

    logic              r1_valid, r1_nan, r1_inf, r1_zero;
    logic [23:0]       r1_sig;
    logic signed [9:0] r1_te;

    always_comb begin
        ed     = i_diff.mag[30:23];
        ed_eff = (ed == '0) ? 8'd1 : ed;
        sig    = {ed != '0, i_diff.mag[22:0]};
        lz     = lzc24(sig);
        n_te   = $signed({2'b00, ed_eff}) - i_diff.ulp_exp - $signed({5'b0, lz});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_nan  <= i_diff.nan;
            r1_inf  <= ({1'b0, i_diff.mag} == INF_BITS);
            r1_zero <= (sig == '0);
            r1_sig  <= sig << lz;
            r1_te   <= n_te;
        end
    end

    // stage 2: pack, or shift into the subnormal range and round
    logic signed [9:0] s_full;
    logic [4:0]  s;
    logic [49:0] x;
    logic [23:0] q;
    logic        up;
    logic [31:0] n_bits;
    logic        r2_valid;
    logic [31:0] r2_bits;

    always_comb begin
        s_full = 10'sd1 - r1_te;
        s      = (s_full > 10'sd26) ? 5'd26 : s_full[4:0];
        x      = {r1_sig, 26'b0} >> s;
        q      = x[49:26];
        up     = x[25] & ((|x[24:0]) | q[0]);
        if (r1_nan) begin
            n_bits = QNAN_BITS;
        end else if (r1_inf || r1_te >= 10'sd255) begin
            n_bits = INF_BITS;
        end else if (r1_zero) begin
            n_bits = '0;
        end else if (r1_te >= 10'sd1) begin
            n_bits = {1'b0, r1_te[7:0], r1_sig[22:0]};
        end else begin
            n_bits = {8'b0, q} + {31'b0, up};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_bits <= n_bits;
        end
    end

    assign o_valid = r2_valid;
    assign o_bits  = r2_bits;

endmodule

`default_nettype wire

/* rtl/float_ulp_error.sv */
// Top level of the float ULP error block: subtractor and scaler pipelines.
// Depends on fue_pkg, fue_if, fue_sub and fue_scale.
//
// Usage:
//   i_in carries one beat per value pair: computed_bits and expected_bits,
//   both IEEE single bit patterns. o_out returns one beat per pair,
//   ulp_error_bits = |computed - expected| / ulp(expected), a nonnegative
//   single value, NaN given as 0x7FC00000, overflow as +inf.
//   An accepted input beat passes these register stages on its way to o_out:
//   four stages of subtraction (unpack/order, align/add, normalize, round)
//   and two of power-of-two scaling (normalize, pack/round).
//   Unless o_out stalls, one beat per cycle; a new pair enters every cycle.
//   Reset clears all stage valid bits; o_out.valid is low after reset and
//   i_in.ready is high.
//   When the receiver holds o_out.ready low with a result waiting, the whole
//   pipeline freezes and i_in.ready drops; bubbles ahead of the output
//   stage keep no ready low. Nothing is lost or repeated.
`default_nettype none

module float_ulp_error (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fue_in_if.sink      i_in,
    fue_out_if.source   o_out
);
    import fue_pkg::*;

    logic  en;
    logic  sub_valid;
    t_diff sub_diff;
    logic  out_valid;

    // advance when the output slot is empty or being drained
    assign en         = !out_valid || o_out.ready;
    assign i_in.ready = en;

    fue_sub u_sub (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in.valid),
        .i_computed (i_in.computed_bits),
        .i_expected (i_in.expected_bits),
        .o_valid    (sub_valid),
        .o_diff     (sub_diff)
    );

    fue_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sub_valid),
        .i_diff  (sub_diff),
        .o_valid (out_valid),
        .o_bits  (o_out.ulp_error_bits)
    );

    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

/* rtl/fue_checker.sv */
// Port-level checker for float_ulp_error, attached by bind.
// Depends on fue_pkg.
`default_nettype none

module fue_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_bits
);
    import fue_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_bits))
        else $error("stalled result changed");

    // results are nonnegative and any NaN is the canonical quiet NaN
    a_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_bits[31] &&
            (i_out_bits[30:23] != EXP_MAX || i_out_bits[22:0] == '0 ||
             i_out_bits == QNAN_BITS))
        else $error("result sign set or NaN not canonical");

    // an empty output slot never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // reset drops the output valid
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind float_ulp_error fue_checker u_fue_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_bits  (o_out.ulp_error_bits)
);

`default_nettype wire
